FILE: sv/fwh_pkg.sv
// ----------------------------------------------------------------------------
// fwh_pkg
// Shared types, constants and the microcode store of the word stream hash.
// ----------------------------------------------------------------------------
package fwh_pkg;

    localparam logic [63:0] ROUND_ADD  = 64'h632B_E59B_D9B4_E019;
    localparam logic [63:0] MUL_A      = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] MUL_B      = 64'hC4CE_B9FE_1A85_EC53;
    localparam int unsigned XS_SHIFT   = 33;
    localparam int unsigned PC_W       = 5;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOADW,
        OP_LOADL,
        OP_MLL,
        OP_MHL,
        OP_MLH,
        OP_XSACC,
        OP_FIN
    } op_t;

    typedef enum logic [1:0] {
        J_NONE,
        J_EMPTY,
        J_NOTLAST
    } jump_t;

    typedef enum logic {
        K_A,
        K_B
    } ksel_t;

    typedef struct packed {
        op_t               op;
        ksel_t             ksel;
        jump_t             jcond;
        logic [PC_W-1:0]   target;
        logic              last_step;
    } ctrl_word_t;

    typedef struct packed {
        logic empty;
        logic last;
    } dp_status_t;

    localparam logic [PC_W-1:0] PC_LEN = 5'd11;
    localparam logic [PC_W-1:0] PC_END = 5'd22;

    function automatic logic [63:0] xorshift(input logic [63:0] v);
        return v ^ (v >> XS_SHIFT);
    endfunction

    function automatic ctrl_word_t mk(input op_t op, input ksel_t ks, input jump_t jc,
                                      input logic [PC_W-1:0] tgt, input logic lst);
        ctrl_word_t w;
        w.op        = op;
        w.ksel      = ks;
        w.jcond     = jc;
        w.target    = tgt;
        w.last_step = lst;
        return w;
    endfunction

    // Absorb the word (steps 1 to 10), then the length (steps 12 to 21).
    function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            5'd0:    w = mk(OP_NOP,   K_A, J_EMPTY,   PC_LEN, 1'b0);
            5'd1:    w = mk(OP_LOADW, K_A, J_NONE,    PC_END, 1'b0);
            5'd2:    w = mk(OP_MLL,   K_A, J_NONE,    PC_END, 1'b0);
            5'd3:    w = mk(OP_MHL,   K_A, J_NONE,    PC_END, 1'b0);
            5'd4:    w = mk(OP_MLH,   K_A, J_NONE,    PC_END, 1'b0);
            5'd5:    w = mk(OP_XSACC, K_A, J_NONE,    PC_END, 1'b0);
            5'd6:    w = mk(OP_MLL,   K_B, J_NONE,    PC_END, 1'b0);
            5'd7:    w = mk(OP_MHL,   K_B, J_NONE,    PC_END, 1'b0);
            5'd8:    w = mk(OP_MLH,   K_B, J_NONE,    PC_END, 1'b0);
            5'd9:    w = mk(OP_FIN,   K_A, J_NOTLAST, PC_END, 1'b0);
            5'd10:   w = mk(OP_NOP,   K_A, J_NONE,    PC_END, 1'b0);
            5'd11:   w = mk(OP_NOP,   K_A, J_NOTLAST, PC_END, 1'b0);
            5'd12:   w = mk(OP_LOADL, K_A, J_NONE,    PC_END, 1'b0);
            5'd13:   w = mk(OP_MLL,   K_A, J_NONE,    PC_END, 1'b0);
            5'd14:   w = mk(OP_MHL,   K_A, J_NONE,    PC_END, 1'b0);
            5'd15:   w = mk(OP_MLH,   K_A, J_NONE,    PC_END, 1'b0);
            5'd16:   w = mk(OP_XSACC, K_A, J_NONE,    PC_END, 1'b0);
            5'd17:   w = mk(OP_MLL,   K_B, J_NONE,    PC_END, 1'b0);
            5'd18:   w = mk(OP_MHL,   K_B, J_NONE,    PC_END, 1'b0);
            5'd19:   w = mk(OP_MLH,   K_B, J_NONE,    PC_END, 1'b0);
            5'd20:   w = mk(OP_FIN,   K_A, J_NONE,    PC_END, 1'b0);
            5'd21:   w = mk(OP_NOP,   K_A, J_NONE,    PC_END, 1'b0);
            default: w = mk(OP_NOP,   K_A, J_NONE,    PC_END, 1'b1);
        endcase
        return w;
    endfunction

endpackage

FILE: sv/fwh_seq.sv
// ----------------------------------------------------------------------------
// fwh_seq
// Step counter and microcode fetch with conditional jumps.
// ----------------------------------------------------------------------------
module fwh_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  can_finish,
    input  fwh_pkg::dp_status_t   status,
    output fwh_pkg::ctrl_word_t   ctrl,
    output logic                  busy,
    output logic                  finish
);

    logic [fwh_pkg::PC_W-1:0] pc_reg;
    logic [fwh_pkg::PC_W-1:0] pc_next;
    logic                     busy_reg;
    logic                     busy_next;
    logic                     taken;

    assign ctrl   = fwh_pkg::rom_word(pc_reg);
    assign busy   = busy_reg;
    assign finish = busy_reg && ctrl.last_step && can_finish;

    always_comb
    begin
        case (ctrl.jcond)
            fwh_pkg::J_EMPTY:   taken = status.empty;
            fwh_pkg::J_NOTLAST: taken = !status.last;
            default:            taken = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                pc_next   = '0;
                busy_next = 1'b1;
            end
        end
        else if (ctrl.last_step)
        begin
            if (can_finish)
            begin
                busy_next = 1'b0;
            end
        end
        else if (taken)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

FILE: sv/fwh_datapath.sv
// ----------------------------------------------------------------------------
// fwh_datapath
// Hash and length registers with one shared 32 by 32 multiplier.
// ----------------------------------------------------------------------------
module fwh_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [63:0]           data_word,
    input  logic [3:0]            valid_bytes,
    input  logic                  end_of_message,
    input  logic                  seed_wr_en,
    input  logic [63:0]           seed_wr_data,
    input  logic                  run,
    input  fwh_pkg::ctrl_word_t   ctrl,
    output fwh_pkg::dp_status_t   status,
    output logic [63:0]           hash
);

    logic [63:0] word_reg;
    logic [3:0]  cnt_reg;
    logic        last_reg;
    logic [63:0] h_reg;
    logic [63:0] len_reg;
    logic [63:0] v_reg;
    logic [63:0] acc_reg;

    logic [3:0]  cnt_clamped;
    logic [63:0] word_masked;
    logic [63:0] k;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    assign cnt_clamped = valid_bytes[3] ? 4'd8 : valid_bytes;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            word_masked[8*i +: 8] = (4'(i) < cnt_clamped) ? data_word[8*i +: 8] : 8'h00;
        end
    end

    assign k     = (ctrl.ksel == fwh_pkg::K_B) ? fwh_pkg::MUL_B : fwh_pkg::MUL_A;
    assign mul_a = (ctrl.op == fwh_pkg::OP_MHL) ? v_reg[63:32] : v_reg[31:0];
    assign mul_b = (ctrl.op == fwh_pkg::OP_MLH) ? k[63:32] : k[31:0];
    assign prod  = {32'b0, mul_a} * {32'b0, mul_b};

    assign status.empty = (cnt_reg == 4'd0);
    assign status.last  = last_reg;
    assign hash         = h_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_masked;
            cnt_reg  <= cnt_clamped;
            last_reg <= end_of_message;
        end
        if (run)
        begin
            case (ctrl.op)
                fwh_pkg::OP_LOADW: v_reg   <= fwh_pkg::xorshift(h_reg ^ word_reg);
                fwh_pkg::OP_LOADL: v_reg   <= fwh_pkg::xorshift(h_reg ^ len_reg);
                fwh_pkg::OP_MLL:   acc_reg <= prod;
                fwh_pkg::OP_MHL:   acc_reg <= acc_reg + {prod[31:0], 32'b0};
                fwh_pkg::OP_MLH:   acc_reg <= acc_reg + {prod[31:0], 32'b0};
                fwh_pkg::OP_XSACC: v_reg   <= fwh_pkg::xorshift(acc_reg);
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg   <= '0;
            len_reg <= '0;
        end
        else
        begin
            if (seed_wr_en)
            begin
                h_reg <= seed_wr_data;
            end
            else if (run && ctrl.op == fwh_pkg::OP_FIN)
            begin
                h_reg <= fwh_pkg::xorshift(acc_reg) + fwh_pkg::ROUND_ADD;
            end
            if (run && ctrl.op == fwh_pkg::OP_LOADW)
            begin
                len_reg <= len_reg + {60'b0, cnt_reg};
            end
            else if (run && ctrl.op == fwh_pkg::OP_LOADL)
            begin
                len_reg <= '0;
            end
        end
    end

endmodule

FILE: sv/fmix64_word_stream_hash.sv
// ----------------------------------------------------------------------------
// fmix64_word_stream_hash
// Chained fmix64 hash over a stream of little-endian message words.
// ----------------------------------------------------------------------------
// Each request on the slave channel carries one message word, its count of
// valid bytes and, on tlast, the end-of-message mark. Each request gives one
// result on the master channel: the chaining value after that word.
// A microcode program drives a single 32 by 32 multiplier; every fmix64 round
// takes six multiply steps, so the multiplier sets the rate. A word with data
// runs a word round; a final word then also runs a length round, and an empty
// word skips the word round. A new request is taken in the same cycle as the
// result is presented, not while the previous one is still being processed.
// The result sits in an output register; while the receiver stalls, the next
// request is still taken and processed, and only its completion waits.
// Reset clears the hash to zero and the byte count to zero. Writing the seed
// loads the hash at once and leaves the byte count unchanged.
// ----------------------------------------------------------------------------
module fmix64_word_stream_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_wr_en,
    input  logic [63:0] seed_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // data_word [63:0], valid_bytes [67:64], zero pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // hash_value [63:0]
);

    fwh_pkg::ctrl_word_t ctrl;
    fwh_pkg::dp_status_t status;
    logic                busy;
    logic                finish;
    logic                start;
    logic                can_finish;
    logic [63:0]         hash;
    logic                out_valid_reg;
    logic [63:0]         out_data_reg;

    assign s_axis_tready = !busy;
    assign start         = s_axis_tvalid && !busy;
    assign can_finish    = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    fwh_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .can_finish (can_finish),
        .status     (status),
        .ctrl       (ctrl),
        .busy       (busy),
        .finish     (finish)
    );

    fwh_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (start),
        .data_word      (s_axis_tdata[63:0]),
        .valid_bytes    (s_axis_tdata[67:64]),
        .end_of_message (s_axis_tlast),
        .seed_wr_en     (seed_wr_en),
        .seed_wr_data   (seed_wr_data),
        .run            (busy),
        .ctrl           (ctrl),
        .status         (status),
        .hash           (hash)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg <= hash;
        end
    end

endmodule

FILE: sv/fwh_checker.sv
// ----------------------------------------------------------------------------
// fwh_checker
// Port-level checks of the word stream hash, bound to the top level.
// ----------------------------------------------------------------------------
module fwh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Only one request is processed at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // The engine frees up only by presenting a result.
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_axis_tready) |-> m_axis_tvalid)
        else $error("ready returned without a result");

    // A result never appears in the cycle after its request.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too early");

endmodule

bind fmix64_word_stream_hash fwh_checker u_fwh_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
